/* rtl/sha_pkg.sv */
// shared types and constants of the sha-256 hash engine
`default_nettype none

package sha_pkg;

	// byte source for the message shift register
	localparam logic [1:0] SRC_IN   = 2'd0;
	localparam logic [1:0] SRC_PAD  = 2'd1;
	localparam logic [1:0] SRC_ZERO = 2'd2;
	localparam logic [1:0] SRC_LEN  = 2'd3;

	localparam int unsigned ROUNDS = 64;

	// standard initial hash value, word 0 in the top bits
	localparam logic [255:0] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] K_TAB = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// controller to datapath commands
	typedef struct packed {
		logic       push;
		logic [1:0] src;
		logic       len_acc;
		logic       var_load;
		logic       round;
		logic [5:0] rnd;
		logic       chain_add;
		logic       dbl_load;
		logic       fin;
	} sha_cmd_t;

	// datapath status back to the controller
	typedef struct packed {
		logic [5:0] fill;
		logic       obuf_busy;
	} sha_sts_t;

endpackage

`default_nettype wire

/* rtl/sha_if.sv */
// item channels of the sha-256 hash engine: message in, digest out, mode write
`default_nettype none

interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source(output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink(input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

interface sha_cfg_if;
	logic valid;
	logic ready;
	logic double_mode;

	modport source(output valid, double_mode, input ready);
	modport sink(input valid, double_mode, output ready);
endinterface

`default_nettype wire

/* rtl/sha_dp.sv */
// sha-256 datapath: message window, round registers, chain value, digest buffer
`default_nettype none

module sha_dp (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sha_pkg::sha_cmd_t cmd,
	input  wire logic [7:0]        in_byte,
	output sha_pkg::sha_sts_t      sts,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            out_word,
	output logic [2:0]             out_idx,
	output logic                   out_last
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	logic [511:0] w_q;      // word 0 in the top bits, oldest first
	logic [31:0]  a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [255:0] chain_q;
	logic [5:0]   fill_q;
	logic [63:0]  len_q;
	logic [255:0] obuf_q;
	logic [2:0]   oidx_q;
	logic         obusy_q;

	logic [31:0]  wt0, wt1, wt9, wt14, w_new;
	logic [31:0]  t1, t2;
	logic [7:0]   push_byte;
	logic [7:0]   len_byte;
	logic [255:0] vars;
	logic [255:0] chain_sum;
	logic         out_take;

	assign wt0  = w_q[511:480];
	assign wt1  = w_q[479:448];
	assign wt9  = w_q[223:192];
	assign wt14 = w_q[63:32];

	// next schedule word
	assign w_new = (rotr(wt14, 17) ^ rotr(wt14, 19) ^ (wt14 >> 10)) + wt9
		+ (rotr(wt1, 7) ^ rotr(wt1, 18) ^ (wt1 >> 3)) + wt0;

	assign t1 = h_q + (rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25))
		+ ((e_q & f_q) ^ (~e_q & g_q)) + sha_pkg::K_TAB[cmd.rnd] + wt0;
	assign t2 = (rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22))
		+ ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

	// length bytes go out most significant first while fill runs 56..63
	assign len_byte = 8'(len_q >> {~fill_q[2:0], 3'b000});

	always_comb begin
		case (cmd.src)
			sha_pkg::SRC_IN:   push_byte = in_byte;
			sha_pkg::SRC_PAD:  push_byte = 8'h80;
			sha_pkg::SRC_ZERO: push_byte = 8'h00;
			sha_pkg::SRC_LEN:  push_byte = len_byte;
			default:           push_byte = 8'h00;
		endcase
	end

	assign vars = {a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q};

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			chain_sum[255 - 32 * i -: 32] = chain_q[255 - 32 * i -: 32] + vars[255 - 32 * i -: 32];
		end
	end

	assign out_take = obusy_q & out_ready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha_pkg::IV;
			fill_q  <= '0;
			len_q   <= '0;
			obusy_q <= 1'b0;
			oidx_q  <= '0;
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.len_acc) begin
				len_q <= len_q + 64'd8;
			end
			if (cmd.chain_add) begin
				chain_q <= chain_sum;
			end
			if (cmd.dbl_load) begin
				chain_q <= sha_pkg::IV;
			end
			if (cmd.fin) begin
				chain_q <= sha_pkg::IV;
				fill_q  <= '0;
				len_q   <= '0;
				obusy_q <= 1'b1;
				oidx_q  <= '0;
			end else if (out_take) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7) begin
					obusy_q <= 1'b0;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			w_q <= {w_q[503:0], push_byte};
		end else if (cmd.round) begin
			w_q <= {w_q[479:0], w_new};
		end else if (cmd.dbl_load) begin
			w_q <= {chain_q, 32'h8000_0000, 192'h0, 32'd256};
		end
		if (cmd.var_load) begin
			{a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q} <= chain_q;
		end else if (cmd.round) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
		end
		if (cmd.fin) begin
			obuf_q <= chain_q;
		end else if (out_take) begin
			obuf_q <= {obuf_q[223:0], 32'h0};
		end
	end

	assign sts.fill      = fill_q;
	assign sts.obuf_busy = obusy_q;

	assign out_valid = obusy_q;
	assign out_word  = obuf_q[255:224];
	assign out_idx   = oidx_q;
	assign out_last  = (oidx_q == 3'd7);

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !obusy_q)
		else $error("digest buffer loaded while still draining");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && oidx_q == 3'd7 && !cmd.fin) |=> !obusy_q)
		else $error("digest buffer busy after last word");

	a_push_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !cmd.round && !cmd.dbl_load && !cmd.var_load)
		else $error("byte push overlaps compression");

endmodule

`default_nettype wire

/* rtl/sha_ctrl.sv */
// sha-256 controller: byte intake, padding sequence, compression rounds, double pass
`default_nettype none

module sha_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              byte_present,
	input  wire logic              end_of_message,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_double_mode,
	input  wire sha_pkg::sha_sts_t sts,
	output sha_pkg::sha_cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CINIT = 4'd1;
	localparam logic [3:0] S_ROUND = 4'd2;
	localparam logic [3:0] S_CADD  = 4'd3;
	localparam logic [3:0] S_PAD80 = 4'd4;
	localparam logic [3:0] S_PADZ  = 4'd5;
	localparam logic [3:0] S_PLEN  = 4'd6;
	localparam logic [3:0] S_POST  = 4'd7;
	localparam logic [3:0] S_DLOAD = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] FILL_LEN  = 6'd56;
	localparam logic [5:0] RND_LAST  = 6'(sha_pkg::ROUNDS - 1);

	logic [3:0] state_q, state_d;
	logic [3:0] ret_q, ret_d;
	logic [5:0] rnd_q, rnd_d;
	logic       mode_q;      // configured double mode
	logic       dbl_q, dbl_d;  // mode sampled on the end item
	logic       second_q, second_d;
	logic       wrap;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign wrap      = (sts.fill == FILL_LAST);

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		rnd_d    = rnd_q;
		dbl_d    = dbl_q;
		second_d = second_q;
		cmd      = '0;
		cmd.rnd  = rnd_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (end_of_message) begin
						dbl_d = mode_q;
					end
					if (byte_present) begin
						cmd.push    = 1'b1;
						cmd.src     = sha_pkg::SRC_IN;
						cmd.len_acc = 1'b1;
					end
					if (byte_present && wrap) begin
						ret_d   = end_of_message ? S_PAD80 : S_IDLE;
						state_d = S_CINIT;
					end else if (end_of_message) begin
						state_d = S_PAD80;
					end
				end
			end
			S_CINIT: begin
				cmd.var_load = 1'b1;
				rnd_d        = '0;
				state_d      = S_ROUND;
			end
			S_ROUND: begin
				cmd.round = 1'b1;
				rnd_d     = rnd_q + 6'd1;
				if (rnd_q == RND_LAST) begin
					state_d = S_CADD;
				end
			end
			S_CADD: begin
				cmd.chain_add = 1'b1;
				state_d       = ret_q;
			end
			S_PAD80: begin
				cmd.push = 1'b1;
				cmd.src  = sha_pkg::SRC_PAD;
				if (wrap) begin
					ret_d   = S_PADZ;
					state_d = S_CINIT;
				end else begin
					state_d = S_PADZ;
				end
			end
			S_PADZ: begin
				if (sts.fill == FILL_LEN) begin
					state_d = S_PLEN;
				end else begin
					cmd.push = 1'b1;
					cmd.src  = sha_pkg::SRC_ZERO;
					if (wrap) begin
						ret_d   = S_PADZ;
						state_d = S_CINIT;
					end
				end
			end
			S_PLEN: begin
				cmd.push = 1'b1;
				cmd.src  = sha_pkg::SRC_LEN;
				if (wrap) begin
					ret_d   = S_POST;
					state_d = S_CINIT;
				end
			end
			S_POST: begin
				state_d = (dbl_q && !second_q) ? S_DLOAD : S_FIN;
			end
			S_DLOAD: begin
				cmd.dbl_load = 1'b1;
				second_d     = 1'b1;
				ret_d        = S_FIN;
				state_d      = S_CINIT;
			end
			S_FIN: begin
				if (!sts.obuf_busy) begin
					cmd.fin  = 1'b1;
					second_d = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			rnd_q    <= '0;
			mode_q   <= 1'b0;
			dbl_q    <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			rnd_q    <= rnd_d;
			dbl_q    <= dbl_d;
			second_q <= second_d;
			if (cfg_valid) begin
				mode_q <= cfg_double_mode;
			end
		end
	end

	a_round_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CINIT) |=> (state_q == S_ROUND && rnd_q == 6'd0))
		else $error("compression did not start at round zero");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && rnd_q == RND_LAST) |=> (state_q == S_CADD))
		else $error("compression ran past the last round");

	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && wrap) |=> (state_q == S_CINIT))
		else $error("full block not sent to compression");

	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLEN) |-> (sts.fill[5:3] == 3'b111))
		else $error("length bytes outside the last eight block bytes");

endmodule

`default_nettype wire

/* rtl/sha256_hash_engine_top.sv */
// top level of the byte-serial sha-256 hash engine
// throughput: a byte per cycle into the block while the controller waits for bytes; intake then
// pauses for each full block's compression (load, 64 rounds, chain add); after the end item, the
// padding bytes (9 to 72) go in and one or two blocks, plus one more in double mode, are compressed
// digest words leave an eight-word buffer one per ready cycle; a finished digest waits for it to empty
// reset: asynchronous, active low; chain value returns to the initial hash, double mode off
`default_nettype none

module sha256_hash_engine_top (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch,
	sha_cfg_if.sink   cfg_ch
);

	// command and status between the controller and the datapath
	sha_pkg::sha_cmd_t cmd;
	sha_pkg::sha_sts_t sts;

	// controller: accepts items only while waiting for message bytes,
	// walks the padding bytes and the rounds of each compression
	sha_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_ch.valid),
		.in_ready        (in_ch.ready),
		.byte_present    (in_ch.byte_present),
		.end_of_message  (in_ch.end_of_message),
		.cfg_valid       (cfg_ch.valid),
		.cfg_ready       (cfg_ch.ready),
		.cfg_double_mode (cfg_ch.double_mode),
		.sts             (sts),
		.cmd             (cmd)
	);

	// datapath: 512-bit message window that doubles as the schedule shift line,
	// eight working variables, chain value, and the digest output buffer
	sha_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_byte   (in_ch.data_byte),
		.sts       (sts),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_word  (out_ch.digest_word),
		.out_idx   (out_ch.word_index),
		.out_last  (out_ch.last_word)
	);

endmodule

`default_nettype wire

/* verif/sha256_hash_engine_top_tb.sv */
// self-checking testbench of the byte-serial sha-256 hash engine with its own digest predictor
`timescale 1ns / 100ps

module sha256_hash_engine_top_tb;

	// no acceptance on any channel for this many cycles ends the run
	localparam int STALL_LIMIT = 5000;
	// quiet time after the last digest word before a mode write or the verdict
	localparam int SETTLE_CYCLES = 400;
	// length of the one long receiver hold-off
	localparam int HOLD_CYCLES = 700;

	// sha-256 round constants and initial hash, kept apart from the design's copies
	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [0:7][31:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// one message item as the sender offers it
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       eom;
	} msg_item_t;

	// one digest word as the engine should return it
	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_word_t;

	// receiver ready patterns
	typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_pattern_e;

	logic clk;
	logic arst_n;

	sha_in_if  msg_ch();
	sha_out_if dig_ch();
	sha_cfg_if mode_ch();

	sha256_hash_engine_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (msg_ch),
		.out_ch (dig_ch),
		.cfg_ch (mode_ch)
	);

	// message items waiting for the sender, filled by the stimulus block
	msg_item_t message_feed[$];
	// digest words the engine still owes, oldest first
	digest_word_t digest_due[$];

	// predictor copy of the engine state
	logic [31:0] chain_hash [8];
	logic [31:0] block_words [16];
	logic [5:0]  block_bytes;
	logic [63:0] bit_length;
	logic        hash_twice;

	int mismatches;
	int items_queued;
	int idle_cycles;

	// sender burst control
	msg_item_t send_item;
	int burst_left;
	int gap_left;

	// receiver stall control
	rx_pattern_e rx_pattern;
	int pattern_left;
	int hold_left;
	logic squeeze_req;
	logic squeeze_done;
	logic rx_take;

	digest_word_t want;

	// 10 ns clock
	always #5 clk = ~clk;

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of block_words into chain_hash
	function automatic void compress_block();
		logic [31:0] w [16];
		logic [31:0] v [8];
		logic [31:0] wr, w15, w2, s0, s1, t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = block_words[i];
		for (int i = 0; i < 8; i++)
			v[i] = chain_hash[i];
		for (int r = 0; r < 64; r++) begin
			if (r < 16) begin
				wr = w[r];
			end else begin
				// rolling 16-word schedule window
				w15 = w[(r + 1) & 15];
				w2 = w[(r + 14) & 15];
				s0 = rotr32(w15, 7) ^ rotr32(w15, 18) ^ (w15 >> 3);
				s1 = rotr32(w2, 17) ^ rotr32(w2, 19) ^ (w2 >> 10);
				wr = w[r & 15] + s0 + w[(r + 9) & 15] + s1;
				w[r & 15] = wr;
			end
			t1 = v[7] + (rotr32(v[4], 6) ^ rotr32(v[4], 11) ^ rotr32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[r] + wr;
			t2 = (rotr32(v[0], 2) ^ rotr32(v[0], 13) ^ rotr32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--)
				v[j] = v[j - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_hash[i] = chain_hash[i] + v[i];
	endfunction

	// big-endian byte placement; bytes after it in the same word are cleared
	function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
		logic [31:0] keep_mask;
		int sh;
		sh = (3 - int'(pos[1:0])) * 8;
		keep_mask = 32'hffffffff << (sh + 8);
		block_words[pos[5:2]] = (block_words[pos[5:2]] & keep_mask) | (32'(b) << sh);
	endfunction

	// takes one accepted message item; an end item appends the eight digest words
	function automatic void absorb_item(input msg_item_t it);
		digest_word_t dw;
		if (it.present) begin
			place_byte(block_bytes, it.data);
			bit_length = bit_length + 64'd8;
			block_bytes = block_bytes + 6'd1;
			if (block_bytes == 6'd0)
				compress_block();
		end
		if (!it.eom)
			return;
		// padding: 0x80, zeros, then the 64-bit length, spilling past 55 bytes
		place_byte(block_bytes, 8'h80);
		for (int j = int'(block_bytes[5:2]) + 1; j < 16; j++)
			block_words[j] = '0;
		if (block_bytes >= 6'd56) begin
			compress_block();
			for (int j = 0; j < 16; j++)
				block_words[j] = '0;
		end
		block_words[14] = bit_length[63:32];
		block_words[15] = bit_length[31:0];
		compress_block();
		// second pass over the 32-byte digest, mode taken at the end item
		if (hash_twice) begin
			for (int j = 0; j < 8; j++)
				block_words[j] = chain_hash[j];
			block_words[8] = 32'h80000000;
			for (int j = 9; j < 15; j++)
				block_words[j] = '0;
			block_words[15] = 32'd256;
			for (int j = 0; j < 8; j++)
				chain_hash[j] = START_HASH[j];
			compress_block();
		end
		for (int j = 0; j < 8; j++) begin
			dw.word = chain_hash[j];
			dw.idx = 3'(j);
			dw.last = (j == 7);
			digest_due.push_back(dw);
		end
		for (int j = 0; j < 8; j++)
			chain_hash[j] = START_HASH[j];
		block_bytes = '0;
		bit_length = '0;
	endfunction

	// items with neither byte nor end are noise and do not count as stimulus
	task automatic push_item(input logic [7:0] d, input logic p, input logic e);
		message_feed.push_back('{data: d, present: p, eom: e});
		if (p || e)
			items_queued++;
	endtask

	// a whole message of random bytes, with the odd noise item mixed in
	task automatic queue_message(input int len, input bit split_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			push_item(8'($urandom_range(0, 255)), 1'b1, !split_end && i == len - 1);
		end
		// the empty message always needs an end item without a byte
		if (split_end || len == 0)
			push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// edge cases: empty message, noise, extreme bytes, both ways of ending
	task automatic queue_directed();
		push_item(8'hff, 1'b0, 1'b1);
		push_item(8'ha5, 1'b0, 1'b0);
		push_item(8'h00, 1'b1, 1'b1);
		push_item(8'hff, 1'b1, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h63, 1'b1, 1'b1);
		push_item(8'h61, 1'b1, 1'b0);
		push_item(8'h62, 1'b1, 1'b0);
		push_item(8'h5a, 1'b0, 1'b0);
		push_item(8'h63, 1'b1, 1'b0);
		push_item(8'h00, 1'b0, 1'b1);
	endtask

	// random messages, mostly short, some on the padding boundaries, some of 110 to 130 bytes
	task automatic random_phase(input int quota, input bit leave_open);
		int start;
		int len;
		int pick;
		start = items_queued;
		while (items_queued - start < quota) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = $urandom_range(0, 12);
			else if (pick < 8)
				case ($urandom_range(0, 5))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					default: len = 65;
				endcase
			else if (pick == 8)
				len = $urandom_range(13, 50);
			else
				len = $urandom_range(110, 130);
			queue_message(len, $urandom_range(0, 3) == 0);
		end
		// stop in the middle of a message so the next mode write lands mid-message
		if (leave_open)
			for (int i = $urandom_range(1, 70); i > 0; i--)
				push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
	endtask

	// mode write, only called while the engine has nothing left to do
	task automatic write_mode(input logic v);
		@(posedge clk);
		mode_ch.valid <= 1'b1;
		mode_ch.double_mode <= v;
		do
			@(posedge clk);
		while (!mode_ch.ready);
		mode_ch.valid <= 1'b0;
	endtask

	// wait for every item to go in and every digest word to come out, then let the engine settle
	task automatic drain();
		while (message_feed.size() != 0 || msg_ch.valid || digest_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// sender: bursts of random length with random gaps, fed from message_feed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!msg_ch.valid || msg_ch.ready) begin
			if (gap_left > 0 || message_feed.size() == 0) begin
				msg_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				send_item = message_feed.pop_front();
				msg_ch.valid <= 1'b1;
				msg_ch.data_byte <= send_item.data;
				msg_ch.byte_present <= send_item.present;
				msg_ch.end_of_message <= send_item.eom;
				// a quarter of the bursts run straight into the next one
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver: changing ready patterns, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_ch.ready <= 1'b0;
			rx_pattern <= RX_OPEN;
			pattern_left <= 0;
			hold_left <= 0;
			squeeze_done <= 1'b0;
		end else begin
			if (hold_left > 0) begin
				rx_take = 1'b0;
				hold_left <= hold_left - 1;
			end else if (squeeze_req && !squeeze_done) begin
				// long hold-off so the output buffer fills and the engine stops taking bytes
				rx_take = 1'b0;
				hold_left <= HOLD_CYCLES;
				squeeze_done <= 1'b1;
			end else begin
				case (rx_pattern)
					RX_OPEN:   rx_take = 1'b1;
					RX_HALF:   rx_take = 1'($urandom_range(0, 1));
					RX_SPARSE: rx_take = ($urandom_range(0, 3) == 0);
					default:   rx_take = !dig_ch.ready;
				endcase
				if (pattern_left == 0) begin
					rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
					pattern_left <= $urandom_range(20, 80);
				end else begin
					pattern_left <= pattern_left - 1;
				end
			end
			dig_ch.ready <= rx_take;
		end
	end

	// monitor: follows mode writes, predicts on accepted items, checks digest words, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (mode_ch.valid && mode_ch.ready)
				hash_twice = mode_ch.double_mode;
			if (msg_ch.valid && msg_ch.ready)
				absorb_item('{data: msg_ch.data_byte, present: msg_ch.byte_present,
					eom: msg_ch.end_of_message});
			if (dig_ch.valid && dig_ch.ready) begin
				if (digest_due.size() == 0) begin
					$error("unexpected digest word %h index %0d", dig_ch.digest_word,
						dig_ch.word_index);
					mismatches++;
				end else begin
					want = digest_due.pop_front();
					if (dig_ch.digest_word !== want.word) begin
						$error("digest_word expected %h actual %h", want.word, dig_ch.digest_word);
						mismatches++;
					end
					if (dig_ch.word_index !== want.idx) begin
						$error("word_index expected %0d actual %0d", want.idx, dig_ch.word_index);
						mismatches++;
					end
					if (dig_ch.last_word !== want.last) begin
						$error("last_word expected %0d actual %0d", want.last, dig_ch.last_word);
						mismatches++;
					end
				end
			end
			// watchdog on cycles with no item moving anywhere
			if ((mode_ch.valid && mode_ch.ready) || (msg_ch.valid && msg_ch.ready)
					|| (dig_ch.valid && dig_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		// every input known from time zero
		clk = 1'b0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.data_byte = '0;
		msg_ch.byte_present = 1'b0;
		msg_ch.end_of_message = 1'b0;
		dig_ch.ready = 1'b0;
		mode_ch.valid = 1'b0;
		mode_ch.double_mode = 1'b0;
		squeeze_req = 1'b0;
		mismatches = 0;
		items_queued = 0;
		idle_cycles = 0;
		// predictor starts from the reset state
		for (int j = 0; j < 8; j++)
			chain_hash[j] = START_HASH[j];
		for (int j = 0; j < 16; j++)
			block_words[j] = '0;
		block_bytes = '0;
		bit_length = '0;
		hash_twice = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed cases, single then double hashing
		write_mode(1'b0);
		queue_directed();
		drain();
		write_mode(1'b1);
		queue_directed();
		drain();

		// random phases; the first one also carries the long receiver hold-off
		write_mode(1'b1);
		random_phase(35, 1'b0);
		squeeze_req <= 1'b1;
		drain();
		write_mode(1'b0);
		random_phase(35, 1'b0);
		drain();
		// this phase leaves a message open across the mode change
		write_mode(1'b1);
		random_phase(35, 1'b1);
		drain();
		write_mode(1'b0);
		random_phase(35, 1'b0);
		drain();

		if (mismatches == 0 && digest_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_dp.sv
rtl/sha_ctrl.sv
rtl/sha256_hash_engine_top.sv
verif/sha256_hash_engine_top_tb.sv
